[sv/rwtg_pkg.sv]
// types, codes and constants shared by the register write transaction guard
`timescale 1ns / 1ps

package rwtg_pkg;

  localparam logic [7:0] KIND_DATA       = 8'd2;
  localparam logic [7:0] KIND_COMMAND    = 8'd3;
  localparam logic [7:0] CMD_MIN_LEN     = 8'd3;
  localparam int unsigned BUSY_STEP_MS   = 100;
  localparam int unsigned BUSY_DEFAULT_MS = 500;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;
  localparam logic [7:0] WRITE_ID_RESET  = 8'd0;
  localparam logic [7:0] RESET_ID_RESET  = 8'd1;
  localparam logic [7:0] BUSY_ID_RESET   = 8'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;

  typedef enum logic [CFG_AW-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_WRITE_ID  = 2'd1,
    CFG_RESET_ID  = 2'd2,
    CFG_BUSY_ID   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    RC_OK      = 3'd0,
    RC_BUSY    = 3'd1,
    RC_CTX     = 3'd2,
    RC_TIMEOUT = 3'd3,
    RC_LEN     = 3'd4,
    RC_PROTO   = 3'd5
  } reply_code_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_COMMIT  = 3'd1,
    ACT_ISSUE   = 3'd2,
    ACT_RESET   = 3'd3,
    ACT_BUSY    = 3'd4,
    ACT_SETTING = 3'd5,
    ACT_UNKNOWN = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    PK_DATA    = 2'd0,
    PK_COMMAND = 2'd1,
    PK_UNKNOWN = 2'd2
  } pkt_class_t;

  typedef enum logic [1:0] {
    ROLE_WRITE = 2'd0,
    ROLE_RESET = 2'd1,
    ROLE_BUSY  = 2'd2,
    ROLE_OTHER = 2'd3
  } role_t;

  typedef struct packed {
    logic [7:0]  packet_kind;
    logic [7:0]  exec_index;
    logic [7:0]  payload_length;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [31:0] now_tick;
    logic        target_ready;
  } in_item_t;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_index;
    reply_code_t reply_code;
    action_t     action;
    logic [7:0]  action_address;
    logic        action_direction;
    logic [7:0]  action_count;
    logic [14:0] busy_timeout_ms;
    logic [7:0]  setting_value;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    pkt_class_t  pclass;
    role_t       role;
    logic        cmd_bad;
    logic        cmd_open;
    logic [7:0]  idx;
    logic [7:0]  len;
    logic [7:0]  b0;
    logic        b1;
    logic [7:0]  b2;
    logic [31:0] now;
    logic [31:0] deadline;
    logic        ready;
    logic [14:0] busy_ms;
  } cls_item_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  write_id;
    logic [7:0]  reset_id;
    logic [7:0]  busy_id;
  } cfg_t;

endpackage

[sv/register_write_transaction_guard.sv]
// top level of the register write transaction guard with its configuration registers
//
//   port group   direction  handshake            payload
//   in           input      in_valid / in_stall   in_item   (in_item_t)
//   out          output     out_valid / out_stall out_item  (out_item_t)
//   cfg          input      cfg_wen               cfg_index, cfg_data
//
// one item per cycle sustained while the queue has room; an accepted item passes
// through the front register, the queue write and then the output register
// the back decides each item combinationally against the pending context
// the four-entry queue lets the front keep accepting while the output is stalled, until it is full
// rst is synchronous; it clears the context and loads register defaults
`timescale 1ns / 1ps

module register_write_transaction_guard import rwtg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_wen,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t      cfg;
  logic      q_push;
  logic      q_full;
  cls_item_t q_data;
  logic      q_pop;
  logic      q_not_empty;
  cls_item_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.write_id      <= WRITE_ID_RESET;
      cfg.reset_id      <= RESET_ID_RESET;
      cfg.busy_id       <= BUSY_ID_RESET;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TIMEOUT:  cfg.timeout_ticks <= cfg_data;
        CFG_WRITE_ID: cfg.write_id      <= cfg_data[7:0];
        CFG_RESET_ID: cfg.reset_id      <= cfg_data[7:0];
        CFG_BUSY_ID:  cfg.busy_id       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rwtg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_data)
  );

  rwtg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rwtg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

[sv/rwtg_front.sv]
// front stage: accepts items, classifies them and precomputes deadline and busy timeout
`timescale 1ns / 1ps

module rwtg_front import rwtg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      q_push,
  input  logic      q_full,
  output cls_item_t q_data
);

  logic      front_valid;
  cls_item_t front_item;
  cls_item_t cls;
  logic      take;
  logic [14:0] step_ms;

  assign q_push   = front_valid && !q_full;
  assign in_stall = front_valid && q_full;
  assign take     = in_valid && !in_stall;
  assign q_data   = front_item;

  always_comb begin
    cls = '0;
    if (in_item.packet_kind == KIND_DATA) begin
      cls.pclass = PK_DATA;
    end else if (in_item.packet_kind == KIND_COMMAND) begin
      cls.pclass = PK_COMMAND;
    end else begin
      cls.pclass = PK_UNKNOWN;
    end
    if (in_item.exec_index == cfg.write_id) begin
      cls.role = ROLE_WRITE;
    end else if (in_item.exec_index == cfg.reset_id) begin
      cls.role = ROLE_RESET;
    end else if (in_item.exec_index == cfg.busy_id) begin
      cls.role = ROLE_BUSY;
    end else begin
      cls.role = ROLE_OTHER;
    end
    cls.cmd_bad  = (in_item.payload_length < CMD_MIN_LEN) || (in_item.byte_one > 8'd1);
    cls.cmd_open = (in_item.byte_one == 8'd1) && (in_item.byte_two != 8'd0);
    cls.idx      = in_item.exec_index;
    cls.len      = in_item.payload_length;
    cls.b0       = in_item.byte_zero;
    cls.b1       = in_item.byte_one[0];
    cls.b2       = in_item.byte_two;
    cls.now      = in_item.now_tick;
    cls.deadline = in_item.now_tick + {16'd0, cfg.timeout_ticks};
    cls.ready    = in_item.target_ready;
    step_ms      = 15'(in_item.byte_zero) * 15'(BUSY_STEP_MS);
    if ((in_item.payload_length != 8'd0) && (in_item.byte_zero != 8'd0)) begin
      cls.busy_ms = step_ms;
    end else begin
      cls.busy_ms = 15'(BUSY_DEFAULT_MS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (take) begin
      front_valid <= 1'b1;
    end else if (q_push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      front_item <= cls;
    end
  end

endmodule

[sv/rwtg_queue.sv]
// short queue of classified items between front and back
`timescale 1ns / 1ps

module rwtg_queue import rwtg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cls_item_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cls_item_t head
);

  cls_item_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_AW:0]      count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/rwtg_back.sv]
// back stage: pending write context, decision and output register
`timescale 1ns / 1ps

module rwtg_back import rwtg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_not_empty,
  input  cls_item_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic        pending_active, pending_active_next;
  logic [7:0]  pending_index, pending_index_next;
  logic [7:0]  pending_address, pending_address_next;
  logic [7:0]  pending_count, pending_count_next;
  logic [31:0] pending_deadline, pending_deadline_next;
  out_item_t   res;

  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    res                   = '0;
    pending_active_next   = pending_active;
    pending_index_next    = pending_index;
    pending_address_next  = pending_address;
    pending_count_next    = pending_count;
    pending_deadline_next = pending_deadline;
    res.reply_index       = q_head.idx;
    res.reply_valid       = 1'b1;
    res.reply_code        = RC_OK;
    res.action            = ACT_NONE;
    if (q_head.pclass == PK_UNKNOWN) begin
      res.reply_valid = 1'b0;
      res.reply_index = '0;
      res.action      = ACT_UNKNOWN;
    end else if (pending_active && (q_head.idx != pending_index)) begin
      res.reply_code = RC_BUSY;
    end else if (q_head.pclass == PK_DATA) begin
      case (q_head.role)
        ROLE_WRITE: begin
          if (!pending_active || (pending_count == 8'd0)) begin
            res.reply_code = RC_CTX;
          end else if (q_head.now > pending_deadline) begin
            res.reply_code      = RC_TIMEOUT;
            pending_active_next = 1'b0;
          end else if (q_head.len != pending_count) begin
            res.reply_code      = RC_LEN;
            pending_active_next = 1'b0;
          end else begin
            res.action          = ACT_COMMIT;
            res.action_address  = pending_address;
            res.action_count    = pending_count;
            pending_active_next = 1'b0;
          end
        end
        ROLE_RESET: begin
          res.action = ACT_RESET;
        end
        ROLE_BUSY: begin
          res.reply_code      = q_head.ready ? RC_OK : RC_BUSY;
          res.action          = ACT_BUSY;
          res.busy_timeout_ms = q_head.busy_ms;
        end
        default: begin
          res.action        = ACT_SETTING;
          res.setting_value = q_head.b0;
        end
      endcase
    end else if (q_head.role != ROLE_WRITE) begin
      res.reply_code = RC_OK;
    end else if (q_head.cmd_bad) begin
      res.reply_code      = RC_PROTO;
      pending_active_next = 1'b0;
    end else if (q_head.cmd_open) begin
      if (pending_active) begin
        if ((pending_address == q_head.b0) && (pending_count == q_head.b2)) begin
          pending_deadline_next = q_head.deadline;
        end else begin
          res.reply_code = RC_BUSY;
        end
      end else begin
        pending_active_next   = 1'b1;
        pending_index_next    = q_head.idx;
        pending_address_next  = q_head.b0;
        pending_count_next    = q_head.b2;
        pending_deadline_next = q_head.deadline;
        res.action            = ACT_ISSUE;
        res.action_address    = q_head.b0;
        res.action_direction  = 1'b1;
        res.action_count      = q_head.b2;
      end
    end else begin
      // read or zero-count write
      res.action           = ACT_ISSUE;
      res.action_address   = q_head.b0;
      res.action_direction = q_head.b1;
      res.action_count     = q_head.b2;
      pending_active_next  = 1'b0;
      if (!q_head.b1) begin
        res.reply_valid = 1'b0;
        res.reply_index = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      pending_active   <= 1'b0;
      pending_index    <= '0;
      pending_address  <= '0;
      pending_count    <= '0;
      pending_deadline <= '0;
    end else if (q_pop) begin
      out_valid        <= 1'b1;
      pending_active   <= pending_active_next;
      pending_index    <= pending_index_next;
      pending_address  <= pending_address_next;
      pending_count    <= pending_count_next;
      pending_deadline <= pending_deadline_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item <= res;
    end
  end

endmodule
